>>> sv/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SKS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);
`define SKS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKS_ASSERT(lbl, clk, rstn, prop, msg)
`define SKS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/sks_pkg.sv
package sks_pkg;

  localparam int MAX_KEEP   = 16;
  localparam int VALUE_BITS = 32;
  localparam int IDX_W      = $clog2(MAX_KEEP);
  localparam int CNT_W      = $clog2(MAX_KEEP + 1);
  localparam int KEEP_W     = 5;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_KEEP_COUNT = CFG_ADDR_W'(0);

  typedef enum logic {
    ST_COLLECT,
    ST_UNLOAD
  } state_t;

  typedef struct packed {
    logic             accept;
    logic             clear_held;
    logic             load_out;
    logic             out_empty;
    logic             out_final;
    logic [IDX_W-1:0] rd_idx;
  } cmd_t;

  typedef struct packed {
    logic              empty_set;
    logic              out_free;
    logic [KEEP_W-1:0] keep;
  } stat_t;

endpackage

>>> sv/sks_dpath.sv
`include "assert_macros.svh"

module sks_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sks_pkg::cmd_t                        cmd,
  output sks_pkg::stat_t                       stat,
  input  logic [sks_pkg::VALUE_BITS-1:0]       in_value,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [sks_pkg::CFG_ADDR_W-1:0]       cfg_paddr,
  input  logic [sks_pkg::CFG_DATA_W-1:0]       cfg_pwdata,
  output logic [sks_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                 cfg_pready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [sks_pkg::VALUE_BITS-1:0]       out_value,
  output logic                                 out_empty,
  output logic                                 out_final
);

  localparam int N = sks_pkg::MAX_KEEP;
  localparam int W = sks_pkg::VALUE_BITS;
  localparam int C = sks_pkg::CNT_W;
  localparam int K = sks_pkg::KEEP_W;

  logic [W-1:0]     store_r [N];
  logic [W-1:0]     store_nxt [N];
  logic [W-1:0]     store_dn [N];
  logic [C-1:0]     held_r, held_nxt;
  logic [K-1:0]     keep_r, keep_nxt;
  logic [W-1:0]     out_value_r, out_value_nxt;
  logic             out_empty_r, out_empty_nxt;
  logic             out_final_r, out_final_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic [N-1:0]     gt;
  logic [N-1:0]     prev_ok;
  logic [C-1:0]     held_m1;
  logic [C-1:0]     base;
  logic [C-1:0]     held_upd;
  logic             do_ins, do_repl, do_upd;
  logic             cfg_wr;

  // config register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    keep_nxt = keep_r;
    if (cfg_wr && cfg_paddr == sks_pkg::REG_KEEP_COUNT) begin
      keep_nxt = cfg_pwdata[K-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == sks_pkg::REG_KEEP_COUNT) begin
      cfg_prdata = {{(sks_pkg::CFG_DATA_W-K){1'b0}}, keep_r};
    end
  end

  // compare row
  always_comb begin
    for (int j = 0; j < N; j++) begin
      gt[j] = $signed(store_r[j]) > $signed(in_value);
    end
    prev_ok = {~gt[N-2:0], 1'b1};
    store_dn[0] = '0;
    for (int j = 1; j < N; j++) begin
      store_dn[j] = store_r[j-1];
    end
  end

  assign held_m1 = held_r - C'(1);
  assign do_ins  = (held_r < C'(keep_r)) && (held_r < C'(N));
  assign do_repl = !do_ins && (held_r != '0) && gt[held_m1[sks_pkg::IDX_W-1:0]];
  assign do_upd  = cmd.accept && (do_ins || do_repl);
  assign base    = do_repl ? held_m1 : held_r;

  always_comb begin
    held_upd = held_r;
    if (cmd.accept && do_ins) begin
      held_upd = held_r + C'(1);
    end
  end

  // insert: keep smaller entries, drop in value, shift larger ones up
  always_comb begin
    for (int j = 0; j < N; j++) begin
      store_nxt[j] = store_r[j];
      if (do_upd) begin
        if (C'(j) < base && !gt[j]) begin
          store_nxt[j] = store_r[j];
        end else if (C'(j) <= base && prev_ok[j]) begin
          store_nxt[j] = in_value;
        end else if (C'(j) <= base) begin
          store_nxt[j] = store_dn[j];
        end
      end
    end
  end

  assign held_nxt = cmd.clear_held ? '0 : held_upd;

  assign stat.empty_set = (keep_r == '0) || (keep_r > K'(N)) || (held_upd < C'(keep_r));
  assign stat.out_free  = !out_valid_r || out_ready;
  assign stat.keep      = keep_r;

  // output register
  always_comb begin
    out_value_nxt = out_value_r;
    out_empty_nxt = out_empty_r;
    out_final_nxt = out_final_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_out) begin
      out_value_nxt = cmd.out_empty ? '0 : store_r[cmd.rd_idx];
      out_empty_nxt = cmd.out_empty;
      out_final_nxt = cmd.out_final;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < N; j++) begin
      store_r[j] <= store_nxt[j];
    end
    out_value_r <= out_value_nxt;
    out_empty_r <= out_empty_nxt;
    out_final_r <= out_final_nxt;
    if (!rst_n) begin
      held_r      <= '0;
      keep_r      <= K'(1);
      out_valid_r <= 1'b0;
    end else begin
      held_r      <= held_nxt;
      keep_r      <= keep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_empty = out_empty_r;
  assign out_final = out_final_r;

  `SKS_ASSERT(a_held_bound, clk, rst_n, held_r <= C'(N), "held count above capacity")

endmodule

>>> sv/sks_ctrl.sv
`include "assert_macros.svh"

module sks_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  input  sks_pkg::stat_t stat,
  output sks_pkg::cmd_t  cmd
);

  localparam int C = sks_pkg::CNT_W;

  sks_pkg::state_t state_r, state_nxt;
  logic [C-1:0]    cnt_r, cnt_nxt;
  logic            empty_r, empty_nxt;
  logic [C-1:0]    cnt_m1;

  assign cnt_m1 = cnt_r - C'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sks_pkg::ST_COLLECT: begin
        if (in_valid && in_last) begin
          state_nxt = sks_pkg::ST_UNLOAD;
        end
      end
      sks_pkg::ST_UNLOAD: begin
        if (stat.out_free && cnt_r == C'(1)) begin
          state_nxt = sks_pkg::ST_COLLECT;
        end
      end
      default: state_nxt = sks_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready       = 1'b0;
    cmd            = '0;
    cnt_nxt        = cnt_r;
    empty_nxt      = empty_r;
    cmd.rd_idx     = cnt_m1[sks_pkg::IDX_W-1:0];
    cmd.out_empty  = empty_r;
    cmd.out_final  = (cnt_r == C'(1));
    unique case (state_r)
      sks_pkg::ST_COLLECT: begin
        in_ready       = 1'b1;
        cmd.accept     = in_valid;
        cmd.clear_held = in_valid && in_last;
        if (in_valid && in_last) begin
          empty_nxt = stat.empty_set;
          cnt_nxt   = stat.empty_set ? C'(1) : C'(stat.keep);
        end
      end
      sks_pkg::ST_UNLOAD: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cnt_nxt      = cnt_m1;
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sks_pkg::ST_COLLECT;
      cnt_r   <= '0;
      empty_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      empty_r <= empty_nxt;
    end
  end

  `SKS_ASSERT(a_last_unloads, clk, rst_n, (in_valid && in_ready && in_last) |=> (state_r == sks_pkg::ST_UNLOAD), "last transaction did not start unload")
  `SKS_ASSERT(a_load_free, clk, rst_n, cmd.load_out |-> stat.out_free, "result loaded over a pending one")
  `SKS_ASSERT(a_unload_cnt, clk, rst_n, (state_r == sks_pkg::ST_UNLOAD) |-> (cnt_r != '0), "unload with zero count")

endmodule

>>> sv/streaming_k_smallest_core.sv
// A set's first result is loaded once unload follows its last accepted transaction.
// Throughput: one input transaction per cycle while collecting; the compare row inserts
// each value combinationally. Unload: one result per cycle while the output is free.
// Input is held off during unload, which gives k results, or 1 if empty.
// Reset: synchronous, active low; clears counts and state, keep_count returns to 1.
module streaming_k_smallest_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [sks_pkg::VALUE_BITS-1:0]        in_tdata,   // [31:0] sample_value
  input  logic                                  in_tlast,   // end_of_set
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [sks_pkg::VALUE_BITS-1:0]        out_tdata,  // [31:0] kept_value
  output logic                                  out_tuser,  // [0] empty_answer
  output logic                                  out_tlast,  // final_result
  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [sks_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [sks_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [sks_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);

  sks_pkg::cmd_t  cmd;
  sks_pkg::stat_t stat;

  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_last  (in_tlast),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sks_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_value    (in_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (out_tdata),
    .out_empty   (out_tuser),
    .out_final   (out_tlast)
  );

endmodule
